// File: rtl/whole_word_occurrence_counter_assert.svh
// assertion macros for the whole-word occurrence counter checker
`ifndef WHOLE_WORD_OCCURRENCE_COUNTER_ASSERT_SVH
`define WHOLE_WORD_OCCURRENCE_COUNTER_ASSERT_SVH

// same-cycle implication
`define WWOC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wwoc check failed");

// next-cycle implication
`define WWOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wwoc check failed");

`endif

// File: rtl/wwoc_pkg.sv
// shared types and constants of the whole-word occurrence counter
`timescale 1ns / 1ps

package wwoc_pkg;

   localparam int CH_BITS        = 8;
   localparam int PAT_CHARS      = 16;
   localparam int PAT_BITS       = PAT_CHARS * CH_BITS;
   localparam int HALF_BITS      = 64;
   localparam int LEN_BITS       = 5;
   localparam int OUT_COUNT_BITS = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam int DEF_MAX_WORD_CHARS = 16;
   localparam int DEF_COUNT_BITS     = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   // scan status codes
   localparam logic [1:0] ST_OUTSIDE  = 2'd0;
   localparam logic [1:0] ST_INSIDE   = 2'd1;
   localparam logic [1:0] ST_MATCHING = 2'd2;

   // delimiters
   localparam logic [CH_BITS-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CH_BITS-1:0] CH_COMMA  = 8'h2c;
   localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_BITS-1:0] CH_LF     = 8'h0a;
   localparam logic [CH_BITS-1:0] CH_PERIOD = 8'h2e;
   localparam logic [CH_BITS-1:0] CH_NUL    = 8'h00;

   // one classified text word between front and back
   typedef struct packed {
      logic                 starts_query;
      logic                 is_delim;
      logic [PAT_CHARS-1:0] hit;
   } item_type;

endpackage

// File: rtl/wwoc_if.sv
// valid/ready channel interfaces for text input and count output
`timescale 1ns / 1ps

interface wwoc_req_if
   import wwoc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CH_BITS-1:0] ch;
   logic               starts_query;

   modport source (output valid, output ch, output starts_query, input ready);
   modport sink   (input valid, input ch, input starts_query, output ready);
endinterface

interface wwoc_rsp_if
   import wwoc_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [OUT_COUNT_BITS-1:0] match_count;
   logic                      word_matched;

   modport source (output valid, output match_count, output word_matched, input ready);
   modport sink   (input valid, input match_count, input word_matched, output ready);
endinterface

// File: rtl/wwoc_front.sv
// front stage: takes a text word and classifies it against the pattern
`timescale 1ns / 1ps

module wwoc_front
   import wwoc_pkg::*;
#(
   parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CH_BITS-1:0]  ch,
   input  logic                starts_query,
   input  logic [PAT_BITS-1:0] pattern,
   output logic                out_valid,
   input  logic                out_ready,
   output item_type            out_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in              = '0;
      item_in.starts_query = starts_query;
      item_in.is_delim     = ch inside {CH_SEMI, CH_COMMA, CH_SPACE, CH_TAB,
                                        CH_LF, CH_PERIOD, CH_NUL};
      // per-position compare, positions past the limit never hit
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
         item_in.hit[i] = (pattern[i*CH_BITS +: CH_BITS] == ch);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/wwoc_queue.sv
// short queue of classified words between front and back
`timescale 1ns / 1ps

module wwoc_queue
   import wwoc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int DEPTH    = QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/wwoc_back.sv
// back stage: scan state, saturating count and output register
`timescale 1ns / 1ps

module wwoc_back
   import wwoc_pkg::*;
#(
   parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS,
   parameter int COUNT_BITS     = DEF_COUNT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [LEN_BITS-1:0]       pattern_length,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  item_type                  in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [OUT_COUNT_BITS-1:0] match_count,
   output logic                      word_matched
);

   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   logic [LEN_BITS-1:0]   matched_ff;
   logic [LEN_BITS-1:0]   matched_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  closed_ff;
   logic                  closed_in;
   logic                  take;
   logic                  len_ok;
   logic                  extend;
   logic [1:0]            st;
   logic [LEN_BITS-1:0]   mc;
   logic [PAT_CHARS-1:0]  sel;

   assign in_ready     = !rsp_valid_ff || out_ready;
   assign take         = in_valid && in_ready;
   assign out_valid    = rsp_valid_ff;
   assign match_count  = OUT_COUNT_BITS'(count_ff);
   assign word_matched = closed_ff;

   assign len_ok = (pattern_length != '0) &&
                   (pattern_length <= LEN_BITS'(MAX_WORD_CHARS));

   always_comb begin
      // a new query clears state before the word is handled
      st       = in_item.starts_query ? ST_OUTSIDE : status_ff;
      mc       = in_item.starts_query ? '0 : matched_ff;
      count_in = in_item.starts_query ? '0 : count_ff;
      sel      = PAT_CHARS'(1) << mc;
      extend   = len_ok && (mc < pattern_length) && ((in_item.hit & sel) != '0);

      status_in  = st;
      matched_in = mc;
      closed_in  = 1'b0;

      if (in_item.is_delim) begin
         if ((st == ST_MATCHING) && len_ok && (mc == pattern_length)) begin
            closed_in = 1'b1;
            if (!(&count_in)) begin
               count_in = count_in + COUNT_BITS'(1);
            end
         end
         status_in  = ST_OUTSIDE;
         matched_in = '0;
      end else begin
         case (st)
            ST_OUTSIDE: begin
               if (extend) begin
                  status_in  = ST_MATCHING;
                  matched_in = LEN_BITS'(1);
               end else begin
                  status_in  = ST_INSIDE;
                  matched_in = '0;
               end
            end
            ST_MATCHING: begin
               if (extend) begin
                  matched_in = mc + LEN_BITS'(1);
               end else begin
                  status_in = ST_INSIDE;
               end
            end
            default: begin
               status_in = st;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_OUTSIDE;
         matched_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            status_ff  <= status_in;
            matched_ff <= matched_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         closed_ff <= closed_in;
      end
   end

endmodule

// File: rtl/whole_word_occurrence_counter.sv
// top level of the whole-word occurrence counter
`timescale 1ns / 1ps

// Counts whole-word occurrences of a search word of up to MAX_WORD_CHARS
// characters in a stream of text words (bytes), one word per req transfer,
// each answered by one rsp word carrying the running count and a flag that
// the byte closed a matching word. Delimiters are ';' ',' space tab
// newline '.' and the zero byte that ends a message. The pattern, its
// length and any change to them must be written through the csr port only
// while no word is in flight; the block does not enforce this. Throughput
// is one byte per clock unless the output stalls; each req word passes the
// front register, queue and output register to its rsp word. starts_query
// clears the count and scan state before its byte. The count saturates at
// 2^COUNT_BITS - 1; match_count shows its low bits.
module whole_word_occurrence_counter
   import wwoc_pkg::*;
#(
   parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS,
   parameter int COUNT_BITS     = DEF_COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   wwoc_req_if.sink                req_bus,
   wwoc_rsp_if.source              rsp_bus,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [HALF_BITS-1:0]    csr_wdata
);

   // configuration registers
   logic [HALF_BITS-1:0] pattern_low_ff;
   logic [HALF_BITS-1:0] pattern_high_ff;
   logic [LEN_BITS-1:0]  pattern_length_ff;

   // front to queue
   logic     front_valid;
   logic     front_ready;
   item_type front_item;

   // queue to back
   logic     back_valid;
   logic     back_ready;
   item_type back_item;

   // an index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_BITS-1:0];
            default: begin
               pattern_low_ff <= pattern_low_ff;
            end
         endcase
      end
   end

   // classify each byte: delimiter flag and per-position pattern hits
   wwoc_front #(
      .MAX_WORD_CHARS (MAX_WORD_CHARS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .ch           (req_bus.ch),
      .starts_query (req_bus.starts_query),
      .pattern      ({pattern_high_ff, pattern_low_ff}),
      .out_valid    (front_valid),
      .out_ready    (front_ready),
      .out_item     (front_item)
   );

   // decouples classification from the scan so each side stalls alone
   wwoc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   // scan state, count and the registered result
   wwoc_back #(
      .MAX_WORD_CHARS (MAX_WORD_CHARS),
      .COUNT_BITS     (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pattern_length (pattern_length_ff),
      .in_valid       (back_valid),
      .in_ready       (back_ready),
      .in_item        (back_item),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .match_count    (rsp_bus.match_count),
      .word_matched   (rsp_bus.word_matched)
   );

endmodule

// File: rtl/wwoc_checker.sv
// port-level checks of the whole-word occurrence counter and their binding
`timescale 1ns / 1ps
`include "whole_word_occurrence_counter_assert.svh"

module wwoc_checker
   import wwoc_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [OUT_COUNT_BITS-1:0] match_count,
   input logic                      word_matched
);

   logic req_take;
   logic wide_count;

   assign req_take   = req_valid && req_ready;
   assign wide_count = (COUNT_BITS > OUT_COUNT_BITS);

   // a stalled result holds
   `WWOC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(match_count) && $stable(word_matched))

   // the block comes out of reset empty and ready
   `WWOC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

   // nothing appears without a word taken in
   `WWOC_ASSERT_NEXT(a_no_phantom, clock, 1'b0, reset ##1 !req_take, !rsp_valid)

   // a closed match is always reflected in the count
   `WWOC_ASSERT_NOW(a_match_counted, clock, reset, rsp_valid && word_matched, wide_count || match_count != '0)

endmodule

bind whole_word_occurrence_counter wwoc_checker #(
   .COUNT_BITS (COUNT_BITS)
) u_wwoc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .match_count  (rsp_bus.match_count),
   .word_matched (rsp_bus.word_matched)
);
